// ===== src/shared_segment_tracker_defines.svh =====
// Assertion helpers for the port checker in src/sst_checker.sv.
`ifndef SHARED_SEGMENT_TRACKER_DEFINES_SVH
`define SHARED_SEGMENT_TRACKER_DEFINES_SVH

// Clocked assertion with reset gating; expects clk_i and rst_ni in scope.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that holds on every result beat; expects out_valid_i and out_ready_i.
`define SST_ASSERT_BEAT(lbl, cons, msg) \
  `SST_ASSERT(lbl, (out_valid_i && out_ready_i) |-> (cons), msg)

`endif

// ===== src/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

  localparam int POS_W     = 25;
  localparam int FRAC_W    = 16;
  localparam int INT_W     = POS_W - FRAC_W;
  localparam int GT_W      = 2;
  localparam int WORD_W    = 64;
  localparam int NUM_BINS  = 512;
  localparam int MAP_WORDS = (NUM_BINS + WORD_W - 1) / WORD_W;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_OUT_W = 3;

  localparam logic [POS_W-1:0]  MIN_LEN_RESET = POS_W'(65536);
  localparam logic [GT_W-1:0]   OPPOSITE_DIFF = GT_W'(2);

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_MAP     = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [GT_W-1:0]  genotype_first;
    logic [GT_W-1:0]  genotype_second;
    logic [POS_W-1:0] position_cm;
    logic             end_of_chromosome;
  } in_item_t;

  typedef struct packed {
    result_kind_e         result_kind;
    logic [POS_W-1:0]     segment_begin;
    logic [POS_W-1:0]     segment_finish;
    logic [POS_W-1:0]     total_shared;
    logic [IDX_OUT_W-1:0] map_word_index;
    logic [WORD_W-1:0]    map_word;
    logic                 last_result;
  } out_item_t;

  // Bin range to set in the map: bins lo..hi inclusive.
  typedef struct packed {
    logic             valid;
    logic [INT_W:0]   lo;
    logic [INT_W-1:0] hi;
  } bin_mark_t;

  typedef struct packed {
    logic             accept;
    logic [POS_W-1:0] seg_begin;
    logic [POS_W-1:0] seg_finish;
    logic [POS_W-1:0] total;
    logic [INT_W:0]   bin_lo;
    logic [INT_W-1:0] bin_hi;
  } seg_result_t;

endpackage

`default_nettype wire

// ===== src/sst_in_if.sv =====
`default_nettype none

interface sst_in_if
  import sst_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sst_out_if.sv =====
`default_nettype none

interface sst_out_if
  import sst_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/shared_segment_tracker.sv =====
// Shared segment tracker: scans a stream of markers for two individuals and
// reports stretches where they are never opposite homozygous. A segment opens
// at the first marker whose genotype codes do not differ by two and closes at
// the next one that does, or at the marker flagged end_of_chromosome. A closed
// segment longer than min_segment_length (Q9.16 cM, strictly greater) yields
// one result beat with its bounds and the saturating running total, and sets
// its whole-cM bins in a 512-bin map. After the last marker the map follows
// as eight 64-bit word beats; last_result marks the final beat of a marker.
// Rate: one marker per cycle while the result slot frees up and no map is
// draining; a marker is registered in the input register on its input beat,
// then scored into the result register once the result slot is free. After a
// marker flagged end_of_chromosome the input stage holds the next marker while
// the single map read port sends one word a cycle, as the result slot frees up.
// Totals and the bin map persist across chromosomes until reset.
// Write min_segment_length only while idle.
`default_nettype none

module shared_segment_tracker
  import sst_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire [POS_W-1:0] cfg_wdata_i,
  sst_in_if.sink          in_i,
  sst_out_if.source       out_o
);

  // Input register.
  in_item_t          a_q;
  logic              a_valid_q;

  // Result register.
  out_item_t         out_q, out_d;
  logic              out_valid_q;

  // Map word sequencer.
  logic              busy_q;
  logic [WIDX_W-1:0] widx_q;

  logic [POS_W-1:0]  min_len_q;

  logic              slot_free;
  logic              fire;
  logic              emit;
  logic              in_beat;
  seg_result_t       seg;
  bin_mark_t         mark;
  logic [WORD_W-1:0] map_word;

  // Advance the held marker when the map is not draining and the result slot frees up.
  assign slot_free = !out_valid_q || out_o.ready;
  assign fire      = a_valid_q && !busy_q && slot_free;
  assign emit      = busy_q && slot_free;
  assign in_i.ready = !a_valid_q || fire;
  assign in_beat   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RESET;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_beat) begin
      a_valid_q <= 1'b1;
    end else if (fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_q <= in_i.data;
    end
  end

  sst_segment u_segment (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (a_q),
    .min_len_i (min_len_q),
    .res_o     (seg)
  );

  always_comb begin
    mark.valid = fire && seg.accept;
    mark.lo    = seg.bin_lo;
    mark.hi    = seg.bin_hi;
  end

  sst_bin_map u_bin_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mark_i    (mark),
    .rd_idx_i  (widx_q),
    .rd_word_o (map_word)
  );

  // Map words start once the last marker has updated the map; drop busy after the final word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      widx_q <= '0;
    end else if (fire && a_q.end_of_chromosome) begin
      busy_q <= 1'b1;
      widx_q <= '0;
    end else if (emit) begin
      widx_q <= widx_q + WIDX_W'(1);
      if (widx_q == WIDX_W'(MAP_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Running total for map words comes from the segment unit's held sum.
  always_comb begin
    out_d = out_q;
    if (emit) begin
      out_d.result_kind    = KIND_MAP;
      out_d.segment_begin  = '0;
      out_d.segment_finish = '0;
      out_d.total_shared   = seg.total;
      out_d.map_word_index = IDX_OUT_W'(widx_q);
      out_d.map_word       = map_word;
      out_d.last_result    = (widx_q == WIDX_W'(MAP_WORDS - 1));
    end else if (fire && seg.accept) begin
      out_d.result_kind    = KIND_SEGMENT;
      out_d.segment_begin  = seg.seg_begin;
      out_d.segment_finish = seg.seg_finish;
      out_d.total_shared   = seg.total;
      out_d.map_word_index = '0;
      out_d.map_word       = '0;
      out_d.last_result    = !a_q.end_of_chromosome;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit || (fire && seg.accept)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ===== src/sst_segment.sv =====
`default_nettype none

module sst_segment
  import sst_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              fire_i,
  input  wire in_item_t    item_i,
  input  wire [POS_W-1:0]  min_len_i,
  output seg_result_t      res_o
);

  logic             open_q, open_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] sum_q, sum_d;

  logic [GT_W-1:0]  diff;
  logic             opposite;
  logic             close_req;
  logic [POS_W-1:0] seg_begin;
  logic [POS_W-1:0] seg_len;
  logic [POS_W:0]   sum_wide;
  logic             accept;

  always_comb begin
    diff = (item_i.genotype_first >= item_i.genotype_second)
         ? item_i.genotype_first - item_i.genotype_second
         : item_i.genotype_second - item_i.genotype_first;
    opposite = (diff == OPPOSITE_DIFF);

    // Close on an opposite homozygote with a segment open, or flush at the last marker.
    close_req = (open_q && opposite) || (item_i.end_of_chromosome && !opposite);
    seg_begin = open_q ? start_q : item_i.position_cm;
    seg_len   = (item_i.position_cm >= seg_begin) ? item_i.position_cm - seg_begin
                                                  : '0;
    // Score only a marker that advances; otherwise the held sum shows through.
    accept    = fire_i && close_req && (seg_len > min_len_i);

    sum_wide = {1'b0, sum_q} + {1'b0, seg_len};
    sum_d    = sum_q;
    if (accept) begin
      sum_d = sum_wide[POS_W] ? {POS_W{1'b1}} : sum_wide[POS_W-1:0];
    end

    open_d  = !opposite && !item_i.end_of_chromosome;
    start_d = (!opposite && !open_q) ? item_i.position_cm : start_q;

    res_o.accept     = accept;
    res_o.seg_begin  = seg_begin;
    res_o.seg_finish = item_i.position_cm;
    res_o.total      = sum_d;
    res_o.bin_lo     = {1'b0, seg_begin[POS_W-1:FRAC_W]} + (INT_W+1)'(1);
    res_o.bin_hi     = item_i.position_cm[POS_W-1:FRAC_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      start_q <= '0;
      sum_q   <= '0;
    end else if (fire_i) begin
      open_q  <= open_d;
      start_q <= start_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/sst_bin_map.sv =====
`default_nettype none

module sst_bin_map
  import sst_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire bin_mark_t    mark_i,
  input  wire [WIDX_W-1:0]  rd_idx_i,
  output logic [WORD_W-1:0] rd_word_o
);

  logic [WORD_W-1:0] map_q [MAP_WORDS];
  logic [WORD_W-1:0] mask  [MAP_WORDS];

  // Range mask: each bin compared against the bounds on its own.
  always_comb begin
    for (int w = 0; w < MAP_WORDS; w++) begin
      for (int i = 0; i < WORD_W; i++) begin
        mask[w][i] = ((w * WORD_W + i) < NUM_BINS)
                  && ((w * WORD_W + i) >= int'(mark_i.lo))
                  && ((w * WORD_W + i) <= int'(mark_i.hi));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= '0;
      end
    end else if (mark_i.valid) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        map_q[w] <= map_q[w] | mask[w];
      end
    end
  end

  assign rd_word_o = map_q[rd_idx_i];

endmodule

`default_nettype wire

// ===== src/sst_checker.sv =====
`default_nettype none
`include "shared_segment_tracker_defines.svh"

module sst_port_checker
  import sst_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            out_valid_i,
  input wire            out_ready_i,
  input wire out_item_t out_data_i
);

  logic [POS_W-1:0] total_q;
  logic             stall;
  logic             seg_ok;
  logic             map_ok;

  // Track the total of the previous result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      total_q <= out_data_i.total_shared;
    end
  end

  assign stall  = out_valid_i && !out_ready_i;
  // A segment beat spans a positive length that the running total covers.
  assign seg_ok = (out_data_i.result_kind != KIND_SEGMENT)
               || ((out_data_i.segment_finish > out_data_i.segment_begin)
                   && (out_data_i.total_shared
                       >= out_data_i.segment_finish - out_data_i.segment_begin));
  assign map_ok = (out_data_i.result_kind != KIND_MAP)
               || (out_data_i.last_result
                   == (out_data_i.map_word_index == IDX_OUT_W'(MAP_WORDS - 1)));

  `SST_ASSERT(a_out_hold, stall |=> (out_valid_i && $stable(out_data_i)), "stalled beat changed")
  `SST_ASSERT_BEAT(a_seg_len, seg_ok, "segment bounds or total inconsistent")
  `SST_ASSERT_BEAT(a_map_last, map_ok, "map word last flag misplaced")
  `SST_ASSERT_BEAT(a_total_mono, out_data_i.total_shared >= total_q, "running total decreased")

endmodule

bind shared_segment_tracker sst_port_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// ===== dv/sst_checker.sv =====
`timescale 1ns / 1ps

module sst_checker
  import sst_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire [POS_W-1:0] cfg_wdata_i,
  sst_in_if               in_i,
  sst_out_if              out_i,
  output int              pending_o,
  output int              errors_o
);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [POS_W-1:0]  min_len;
  logic              run_open;
  logic [POS_W-1:0]  run_start;
  logic [POS_W-1:0]  shared_total;
  logic [WORD_W-1:0] shared_bins [MAP_WORDS];
  out_item_t         step_res [MAP_WORDS+1];
  int                step_cnt;
  out_item_t         expected_q [$];
  int                err_cnt;

  // Append one predicted result beat behind those already owed.
  function automatic void queue_result(out_item_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  // Score a closed run; a long enough one adds to the total and the bin map.
  function automatic void close_run(logic [POS_W-1:0] first_pos, logic [POS_W-1:0] last_pos);
    logic [POS_W-1:0] run_len;
    logic [POS_W:0]   sum;
    int               lo;
    int               hi;
    run_len = (last_pos >= first_pos) ? last_pos - first_pos : '0;
    if (run_len <= min_len) return;
    sum = {1'b0, shared_total} + {1'b0, run_len};
    shared_total = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    lo = int'(first_pos[POS_W-1:FRAC_W]) + 1;
    hi = int'(last_pos[POS_W-1:FRAC_W]);
    for (int b = lo; b <= hi; b++) begin
      if (b < NUM_BINS) shared_bins[b / WORD_W][b % WORD_W] = 1'b1;
    end
    step_res[step_cnt] = '{KIND_SEGMENT, first_pos, last_pos, shared_total, '0, '0, 1'b0};
    step_cnt++;
  endfunction

  function automatic void predict_marker(in_item_t m);
    logic [GT_W-1:0] diff;
    diff = (m.genotype_first >= m.genotype_second) ?
           m.genotype_first - m.genotype_second : m.genotype_second - m.genotype_first;
    step_cnt = 0;
    if (diff != OPPOSITE_DIFF) begin
      if (!run_open) begin
        run_open  = 1'b1;
        run_start = m.position_cm;
      end
    end else if (run_open) begin
      close_run(run_start, m.position_cm);
      run_open = 1'b0;
    end
    if (m.end_of_chromosome) begin
      if (run_open) begin
        close_run(run_start, m.position_cm);
        run_open = 1'b0;
      end
      for (int w = 0; w < MAP_WORDS; w++) begin
        step_res[step_cnt] = '{KIND_MAP, '0, '0, shared_total, IDX_OUT_W'(w), shared_bins[w],
                               1'b0};
        step_cnt++;
      end
    end
    if (step_cnt > 0) step_res[step_cnt-1].last_result = 1'b1;
    for (int k = 0; k < step_cnt; k++) queue_result(step_res[k]);
  endfunction

  function automatic int field_differs(string field, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
    if (want === got) return 0;
    $error("%s: expected %0h, got %0h", field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    int        bad;
    if (!rst_ni) begin
      min_len      = MIN_LEN_RESET;
      run_open     = 1'b0;
      run_start    = '0;
      shared_total = '0;
      for (int w = 0; w < MAP_WORDS; w++) shared_bins[w] = '0;
      expected_q.delete();
      err_cnt      = 0;
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      if (cfg_we_i) min_len = cfg_wdata_i;
      if (in_i.valid && in_i.ready) predict_marker(in_i.data);
      if (out_i.valid && out_i.ready) begin
        got = out_i.data;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          bad  = 0;
          bad += field_differs("result_kind", 64'(want.result_kind), 64'(got.result_kind));
          bad += field_differs("segment_begin", 64'(want.segment_begin), 64'(got.segment_begin));
          bad += field_differs("segment_finish", 64'(want.segment_finish),
                               64'(got.segment_finish));
          bad += field_differs("total_shared", 64'(want.total_shared), 64'(got.total_shared));
          bad += field_differs("map_word_index", 64'(want.map_word_index),
                               64'(got.map_word_index));
          bad += field_differs("map_word", want.map_word, got.map_word);
          bad += field_differs("last_result", 64'(want.last_result), 64'(got.last_result));
          if (bad != 0) err_cnt++;
        end
      end
      pending_o <= expected_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

// ===== dv/tb_shared_segment_tracker.sv =====
`timescale 1ns / 1ps

module tb_shared_segment_tracker;
  import sst_pkg::*;

  localparam int               IN_W             = $bits(in_item_t);
  localparam logic [POS_W-1:0] POS_MAX          = '1;
  localparam logic [POS_W-1:0] ONE_CM           = POS_W'(65536);
  localparam int               CYCLE_LIMIT      = 400000;
  // Covers the input and result registers plus the eight map word beats that
  // follow a last marker, with margin.
  localparam int               SETTLE_CYCLES    = 24;
  localparam int               LONG_HOLD_CYCLES = 120;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [POS_W-1:0] cfg_wdata_i;

  int pending;
  int errors;
  int cycle_cnt = 0;
  bit idle_on;
  bit hold_req;

  sst_in_if  in_if ();
  sst_out_if out_if ();

  shared_segment_tracker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // The checker predicts from the beats it sees and reports how many results
  // are still owed and how many mismatches it found.
  sst_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_i      (out_if),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog: end the run if it stalls far beyond the slowest correct case.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_shared_segment_tracker: FAIL");
      $finish;
    end
  end

  // Result side. Drop ready in short random bursts while idling is on, and
  // hold it low for a long stretch on request so the block backs up.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        hold_req     = 1'b0;
        out_if.ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready = 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Offer one marker beat; return at the falling edge after it was taken.
  // Valid stays high into the next call, so back-to-back beats have no gap unless idling inserts one.
  task automatic send_marker(input in_item_t m);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap          = $urandom_range(1, 8);
      in_if.valid  = 1'b0;
      in_if.data   = IN_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_if.data  = m;
    in_if.valid = 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
    end
    @(negedge clk_i);
  endtask

  task automatic put_marker(input int g1, input int g2, input logic [POS_W-1:0] pos,
                            input bit last);
    in_item_t m;
    m.genotype_first    = GT_W'(g1);
    m.genotype_second   = GT_W'(g2);
    m.position_cm       = pos;
    m.end_of_chromosome = last;
    send_marker(m);
  endtask

  // Drain, let the block go quiet, then change the length threshold.
  task automatic write_min_len(input logic [POS_W-1:0] value);
    in_if.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Send whole chromosomes until about n_items markers went out. Most markers
  // walk forward from a random start with small steps and the odd long jump;
  // about one in six is opposite homozygous, which closes a run. A few are
  // pure noise: any codes, code 3 included, and any position, even backwards.
  task automatic send_random(input int n_items);
    in_item_t         m;
    logic [POS_W-1:0] pos;
    logic [POS_W:0]   next_pos;
    int               sent;
    int               n_markers;
    int               step;
    int               g1;
    int               g2;
    sent = 0;
    while (sent < n_items) begin
      n_markers = $urandom_range(1, 40);
      pos       = POS_W'($urandom_range(0, 500 * 65536));
      for (int k = 0; k < n_markers; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          m = IN_W'($urandom);
        end else begin
          step     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8 * 65536)
                                                 : $urandom_range(0, 16384);
          next_pos = {1'b0, pos} + (POS_W + 1)'(step);
          pos      = next_pos[POS_W] ? POS_MAX : next_pos[POS_W-1:0];
          if ($urandom_range(0, 5) == 0) begin
            g1 = ($urandom_range(0, 1) == 0) ? 0 : 2;
            g2 = 2 - g1;
          end else begin
            do begin
              g1 = $urandom_range(0, 2);
              g2 = $urandom_range(0, 2);
            end while ((g1 == 0 && g2 == 2) || (g1 == 2 && g2 == 0));
          end
          m.genotype_first  = GT_W'(g1);
          m.genotype_second = GT_W'(g2);
          m.position_cm     = pos;
        end
        m.end_of_chromosome = (k == n_markers - 1);
        send_marker(m);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed markers at the reset threshold of one cM.
    put_marker(0, 0, 25'h0000000, 1'b0);   // open at zero
    put_marker(1, 1, 25'h0010000, 1'b0);
    put_marker(2, 0, 25'h0030000, 1'b0);   // close, accepted, bins 1..3
    put_marker(0, 2, 25'h0030000, 1'b0);   // opposite with nothing open
    put_marker(1, 2, 25'h0040000, 1'b0);
    put_marker(2, 1, 25'h0048000, 1'b0);
    put_marker(0, 2, 25'h0050000, 1'b0);   // length equals threshold: dropped
    put_marker(1, 2, 25'h0050000, 1'b0);
    put_marker(2, 0, 25'h0060001, 1'b0);   // one step over threshold: accepted
    put_marker(3, 1, 25'h0070000, 1'b0);   // code 3 against 1 counts as opposite
    put_marker(3, 0, 25'h0070000, 1'b0);   // code 3 against 0 does not
    put_marker(3, 3, 25'h0090000, 1'b0);
    put_marker(1, 3, 25'h0060000, 1'b0);   // position steps back: zero length
    put_marker(2, 2, 25'h1F00000, 1'b0);
    put_marker(0, 1, POS_MAX, 1'b0);
    put_marker(0, 2, POS_MAX, 1'b0);       // accepted, reaches the top bin
    put_marker(2, 0, POS_MAX, 1'b1);       // last marker, nothing open
    put_marker(1, 1, 25'h0100000, 1'b0);
    put_marker(1, 0, 25'h01C0000, 1'b1);   // last marker flushes an open run
    put_marker(0, 0, 25'h0200000, 1'b0);
    put_marker(2, 0, 25'h02A0000, 1'b1);   // last marker that is itself opposite
    put_marker(0, 0, 25'h0300000, 1'b1);   // run opens and closes on one marker

    // Zero threshold; start with a long receiver hold while markers keep coming.
    write_min_len('0);
    hold_req = 1'b1;
    send_random(100);

    // Highest threshold: nothing can be accepted, only map words come out.
    write_min_len(POS_MAX);
    send_random(20);

    write_min_len(POS_W'($urandom_range(0, 3 * 65536)));
    send_random(110);

    // Last part runs with no idling on either side.
    write_min_len(ONE_CM / 2);
    idle_on = 1'b0;
    send_random(90);

    // Saturate the running total with full-range runs.
    put_marker(1, 1, 25'h0000000, 1'b0);
    put_marker(0, 2, POS_MAX, 1'b0);
    put_marker(1, 1, 25'h0010000, 1'b0);
    put_marker(2, 0, POS_MAX, 1'b1);

    in_if.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_shared_segment_tracker: PASS");
    end else begin
      $display("tb_shared_segment_tracker: FAIL");
    end
    $finish;
  end

endmodule
